// ----- sv/spkt_pkg.sv -----
// Shared types and constants for the space packet hit decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package spkt_pkg;

	// Bit accumulator for hit records and the counters that go with it.
	localparam int ACC_W   = 52;
	localparam int HELD_W  = 6;
	localparam int AVAIL_W = 14;
	localparam int IDX_W   = 17;
	localparam int HBL_W   = 10;

	// Accepted application process identifiers.
	localparam logic [10:0] APID_A = 11'h0DD;
	localparam logic [10:0] APID_B = 11'h0E2;
	localparam logic [10:0] APID_C = 11'h0E3;

	// Parse phases.
	localparam logic [2:0] PH_PRIMARY = 3'd0;
	localparam logic [2:0] PH_TIME    = 3'd1;
	localparam logic [2:0] PH_SCIENCE = 3'd2;
	localparam logic [2:0] PH_HITS    = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;

	// Result kinds.
	localparam logic [2:0] RK_HIT      = 3'd0;
	localparam logic [2:0] RK_OK       = 3'd1;
	localparam logic [2:0] RK_MISMATCH = 3'd2;
	localparam logic [2:0] RK_SHORT    = 3'd3;
	localparam logic [2:0] RK_BAD_APID = 3'd4;
	localparam logic [2:0] RK_OVERLONG = 3'd5;

	// Hit record type codes as they appear in the leading nibble.
	localparam logic [3:0] REC_NORMAL   = 4'd0;
	localparam logic [3:0] REC_NEIGHBOR = 4'd1;
	localparam logic [3:0] REC_GUARD    = 4'd2;
	localparam logic [3:0] REC_PULSER   = 4'd3;

	// Record lengths in bits, type nibble included.
	localparam logic [5:0] NEED_FULL     = 6'd44;
	localparam logic [5:0] NEED_NEIGHBOR = 6'd36;
	localparam logic [5:0] NEED_GUARD    = 6'd24;
	localparam logic [5:0] MIN_BITS      = 6'd4;

	// Header sizes in bytes.
	localparam int TIME_HDR_BYTES = 8;
	localparam int SCI_HDR_BYTES  = 7;

	// Output queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [1:0]  hit_kind;
		logic [10:0] readout_id;
		logic        fast_timing;
		logic [13:0] adc_value;
		logic [13:0] tac_value;
		logic [31:0] time_seconds;
		logic [31:0] time_subticks;
		logic [5:0]  hits_decoded;
		logic        guard_veto;
		logic        last_of_packet;
	} result_t;

	// What the record unpacker reports for one byte step.
	typedef struct packed {
		logic              emit;
		logic              stop;
		logic [1:0]        hit_kind;
		logic [10:0]       readout_id;
		logic              fast_timing;
		logic [13:0]       adc_value;
		logic [13:0]       tac_value;
		logic              veto;
		logic [HELD_W-1:0] held_left;
		logic [ACC_W-1:0]  acc_left;
	} dec_t;

endpackage

// ----- sv/space_packet_hit_decoder.sv -----
// Space packet hit decoder, top level. A byte's results are registered into
// the result queue at its transaction. Throughput: one byte per cycle; in_ready
// is set by the four-entry result queue, which must have room for two results
// (a hit and a packet end can share a byte).
// Reset (arst_n low) clears the parser and the queue at once; no clearing pass.
`timescale 1ns / 1ps

module space_packet_hit_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [1:0]  hit_kind,
	output logic [10:0] readout_id,
	output logic        fast_timing,
	output logic [13:0] adc_value,
	output logic [13:0] tac_value,
	output logic [31:0] time_seconds,
	output logic [31:0] time_subticks,
	output logic [5:0]  hits_decoded,
	output logic        guard_veto,
	output logic        last_of_packet
);
	import spkt_pkg::*;

	logic       take;
	logic       room;
	logic [1:0] push_n;
	result_t    res_a;
	result_t    res_b;
	result_t    head;

	// A byte transaction completes whenever the queue can absorb the worst
	// case of two results, so the input side never waits on the parse state.
	assign in_ready = room;
	assign take     = in_valid && in_ready;

	// The parser does all per-byte work combinationally: header fields, the bit
	// accumulator and the hit record unpacker, writing results to the queue.
	spkt_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.push_n    (push_n),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	// The queue separates the two sides: results wait here while new bytes
	// keep flowing in.
	spkt_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign result_kind    = head.result_kind;
	assign hit_kind       = head.hit_kind;
	assign readout_id     = head.readout_id;
	assign fast_timing    = head.fast_timing;
	assign adc_value      = head.adc_value;
	assign tac_value      = head.tac_value;
	assign time_seconds   = head.time_seconds;
	assign time_subticks  = head.time_subticks;
	assign hits_decoded   = head.hits_decoded;
	assign guard_veto     = head.guard_veto;
	assign last_of_packet = head.last_of_packet;

endmodule

// ----- sv/spkt_hit_unpack.sv -----
// Combinational hit record unpacker: classifies and extracts one record
// from the bit accumulator. Depends on spkt_pkg.
`timescale 1ns / 1ps

module spkt_hit_unpack (
	input  logic [spkt_pkg::ACC_W-1:0]   acc,
	input  logic [spkt_pkg::HELD_W-1:0]  held,
	input  logic [spkt_pkg::AVAIL_W-1:0] avail,
	input  logic [5:0]                   hits_done,
	input  logic [5:0]                   exp_hits,
	output spkt_pkg::dec_t               dec
);
	import spkt_pkg::*;

	localparam logic [1:0] DC_WAIT = 2'd0;
	localparam logic [1:0] DC_STOP = 2'd1;
	localparam logic [1:0] DC_EMIT = 2'd2;

	function automatic logic [5:0] rec_need(input logic [3:0] nib);
		logic [5:0] need;
		case (nib)
			REC_NORMAL, REC_PULSER: need = NEED_FULL;
			REC_NEIGHBOR:           need = NEED_NEIGHBOR;
			REC_GUARD:              need = NEED_GUARD;
			default:                need = 6'd0;
		endcase
		return need;
	endfunction

	function automatic logic [1:0] classify(
		input logic [HELD_W-1:0]  h,
		input logic [AVAIL_W-1:0] av,
		input logic [5:0]         done,
		input logic [5:0]         exp_cnt,
		input logic [3:0]         nib
	);
		logic [5:0] need;
		logic [1:0] res;
		need = rec_need(nib);
		if (done >= exp_cnt) res = DC_STOP;
		else if (av < AVAIL_W'(MIN_BITS)) res = DC_STOP;
		else if (h < MIN_BITS) res = DC_WAIT;
		else if (need == 6'd0) res = DC_STOP;
		else if (av < AVAIL_W'(need)) res = DC_STOP;
		else if (h < need) res = DC_WAIT;
		else res = DC_EMIT;
		return res;
	endfunction

	logic [ACC_W-1:0]   aligned;
	logic [ACC_W-1:0]   aligned2;
	logic [3:0]         nib1;
	logic [5:0]         need1;
	logic [1:0]         cls1;
	logic [1:0]         cls2;
	logic [HELD_W-1:0]  held2;
	logic [AVAIL_W-1:0] avail2;
	logic [5:0]         done2;
	logic [ACC_W-1:0]   keep_mask;

	always_comb begin
		// Put the oldest held bit at the top so fields sit at fixed places.
		aligned   = acc << (HELD_W'(ACC_W) - held);
		nib1      = aligned[ACC_W-1 -: 4];
		need1     = rec_need(nib1);
		cls1      = classify(held, avail, hits_done, exp_hits, nib1);
		held2     = held - need1;
		avail2    = avail - AVAIL_W'(need1);
		done2     = hits_done + 6'd1;
		aligned2  = aligned << need1;
		cls2      = classify(held2, avail2, done2, exp_hits, aligned2[ACC_W-1 -: 4]);
		keep_mask = (ACC_W'(1) << held2) - ACC_W'(1);

		dec = '0;
		dec.emit = (cls1 == DC_EMIT);
		// After a record is taken the loop looks once more; it can only stop or wait.
		dec.stop = dec.emit ? (cls2 == DC_STOP) : (cls1 == DC_STOP);
		dec.hit_kind = nib1[1:0];
		dec.held_left = dec.emit ? held2 : held;
		dec.acc_left = dec.emit ? (acc & keep_mask) : acc;
		case (nib1)
			REC_NEIGHBOR: begin
				dec.readout_id  = aligned[47:37];
				dec.fast_timing = aligned[36];
				dec.adc_value   = {4'd0, aligned[35:26]};
				dec.tac_value   = {4'd0, aligned[25:16]};
			end
			REC_GUARD: begin
				dec.readout_id = {6'd0, aligned[47:43]};
				dec.adc_value  = aligned[42:29];
				dec.veto       = 1'b1;
			end
			default: begin
				dec.readout_id  = aligned[47:37];
				dec.fast_timing = aligned[36];
				dec.adc_value   = aligned[35:22];
				dec.tac_value   = aligned[21:8];
			end
		endcase
	end

endmodule

// ----- sv/spkt_parser.sv -----
// Packet parser: header state, hit-data accumulation and result building
// for one byte per cycle while take is high. Depends on spkt_pkg and spkt_hit_unpack.
`timescale 1ns / 1ps

module spkt_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	output logic [1:0]           push_n,
	output spkt_pkg::result_t    res_a,
	output spkt_pkg::result_t    res_b
);
	import spkt_pkg::*;

	localparam logic [IDX_W-1:0] PRI_ID_HI  = 17'd0;
	localparam logic [IDX_W-1:0] PRI_ID_LO  = 17'd1;
	localparam logic [IDX_W-1:0] PRI_LEN_HI = 17'd4;
	localparam logic [IDX_W-1:0] PRI_LEN_LO = 17'd5;
	localparam logic [IDX_W-1:0] TIME_SEC_END = 17'd4;
	localparam logic [IDX_W-1:0] TIME_LAST    = 17'd7;
	localparam logic [IDX_W-1:0] SCI_COUNT    = 17'd4;
	localparam logic [IDX_W-1:0] SCI_LEN_LO   = 17'd5;
	localparam logic [IDX_W-1:0] SCI_TYPE     = 17'd6;

	logic [2:0]        phase_q, phase_d;
	logic [IDX_W-1:0]  byte_idx_q, byte_idx_d;
	logic [IDX_W-1:0]  pay_len_q, pay_len_d;
	logic              has_time_q, has_time_d;
	logic [15:0]       hdr_q, hdr_d;
	logic [31:0]       seconds_q, seconds_d;
	logic [31:0]       subticks_q, subticks_d;
	logic [5:0]        exp_hits_q, exp_hits_d;
	logic [HBL_W-1:0]  hit_bytes_q, hit_bytes_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [HELD_W-1:0] bits_q, bits_d;
	logic [5:0]        hits_done_q, hits_done_d;
	logic              dec_stop_q, dec_stop_d;
	logic              veto_q, veto_d;
	logic              halted_q, halted_d;

	logic [HBL_W-1:0]   hbl_dec;
	logic [HBL_W-1:0]   hbl_lo;
	logic [IDX_W-1:0]   base;
	logic [IDX_W-1:0]   sci_off;
	logic [IDX_W-1:0]   idx_inc;
	logic [IDX_W-1:0]   pl_full;
	logic               run;
	logic [ACC_W-1:0]   acc_in;
	logic [HELD_W-1:0]  held_in;
	logic [AVAIL_W-1:0] avail_in;
	logic               apid_ok;
	logic               step;
	logic               err;
	logic               hit_emit;
	logic               pkt_end;
	logic [2:0]         err_kind;
	result_t            hit_res;
	result_t            end_res;
	dec_t               dec;

	spkt_hit_unpack u_unpack (
		.acc       (acc_in),
		.held      (held_in),
		.avail     (avail_in),
		.hits_done (hits_done_q),
		.exp_hits  (exp_hits_q),
		.dec       (dec)
	);

	always_comb begin
		phase_d     = phase_q;
		byte_idx_d  = byte_idx_q;
		pay_len_d   = pay_len_q;
		has_time_d  = has_time_q;
		hdr_d       = hdr_q;
		seconds_d   = seconds_q;
		subticks_d  = subticks_q;
		exp_hits_d  = exp_hits_q;
		hit_bytes_d = hit_bytes_q;
		acc_d       = acc_q;
		bits_d      = bits_q;
		hits_done_d = hits_done_q;
		dec_stop_d  = dec_stop_q;
		veto_d      = veto_q;
		halted_d    = halted_q;

		hbl_dec  = hit_bytes_q - HBL_W'(1);
		hbl_lo   = {hit_bytes_q[9:8], data_byte};
		base     = has_time_q ? IDX_W'(TIME_HDR_BYTES) : '0;
		sci_off  = byte_idx_q - base;
		idx_inc  = byte_idx_q + IDX_W'(1);
		pl_full  = {1'b0, pay_len_q[15:8], data_byte} + IDX_W'(1);
		run      = (phase_q == PH_HITS) && !dec_stop_q;
		acc_in   = run ? {acc_q[ACC_W-9:0], data_byte} : acc_q;
		held_in  = run ? (bits_q + HELD_W'(8)) : bits_q;
		avail_in = AVAIL_W'(held_in) + {1'b0, hbl_dec, 3'b000};
		apid_ok  = hdr_q[10:0] inside {APID_A, APID_B, APID_C};

		step     = 1'b0;
		err      = 1'b0;
		err_kind = RK_BAD_APID;
		hit_emit = 1'b0;
		pkt_end  = 1'b0;

		if (take && !halted_q) begin
			case (phase_q)
				PH_PRIMARY: begin
					byte_idx_d = idx_inc;
					if (byte_idx_q == PRI_ID_HI) begin
						hdr_d = {data_byte, 8'h00};
					end else if (byte_idx_q == PRI_ID_LO) begin
						hdr_d = {hdr_q[15:8], data_byte};
					end else if (byte_idx_q == PRI_LEN_HI) begin
						pay_len_d = {1'b0, data_byte, 8'h00};
					end else if (byte_idx_q == PRI_LEN_LO) begin
						pay_len_d  = pl_full;
						has_time_d = hdr_q[11];
						byte_idx_d = byte_idx_q;
						if (!apid_ok) begin
							err      = 1'b1;
							err_kind = RK_BAD_APID;
						end else if (pl_full < (hdr_q[11] ?
							IDX_W'(TIME_HDR_BYTES + SCI_HDR_BYTES) :
							IDX_W'(SCI_HDR_BYTES))) begin
							err      = 1'b1;
							err_kind = RK_SHORT;
						end else begin
							phase_d    = hdr_q[11] ? PH_TIME : PH_SCIENCE;
							byte_idx_d = '0;
						end
					end
				end
				PH_TIME: begin
					step = 1'b1;
					if (byte_idx_q < TIME_SEC_END) seconds_d = {seconds_q[23:0], data_byte};
					else subticks_d = {subticks_q[23:0], data_byte};
					if (byte_idx_q == TIME_LAST) phase_d = PH_SCIENCE;
				end
				PH_SCIENCE: begin
					step = 1'b1;
					if (sci_off == SCI_COUNT) begin
						exp_hits_d  = data_byte[7:2];
						hit_bytes_d = {data_byte[1:0], 8'h00};
					end else if (sci_off == SCI_LEN_LO) begin
						hit_bytes_d = hbl_lo;
						if (pay_len_q < base + IDX_W'(SCI_HDR_BYTES) + IDX_W'(hbl_lo)) begin
							step     = 1'b0;
							err      = 1'b1;
							err_kind = RK_OVERLONG;
						end
					end else if (sci_off == SCI_TYPE) begin
						phase_d = (hit_bytes_q != '0) ? PH_HITS : PH_SKIP;
					end
				end
				PH_HITS: begin
					step        = 1'b1;
					hit_bytes_d = hbl_dec;
					if (run) begin
						if (dec.emit) begin
							hit_emit    = 1'b1;
							acc_d       = dec.acc_left;
							bits_d      = dec.held_left;
							hits_done_d = hits_done_q + 6'd1;
							if (dec.veto) veto_d = 1'b1;
						end else begin
							acc_d  = acc_in;
							bits_d = held_in;
						end
						if (dec.stop) dec_stop_d = 1'b1;
					end
					if (hbl_dec == '0) begin
						phase_d    = PH_SKIP;
						dec_stop_d = 1'b1;
					end
				end
				default: begin
					step = 1'b1;
				end
			endcase

			if (err) halted_d = 1'b1;
		end

		if (step) begin
			byte_idx_d = idx_inc;
			pkt_end = (idx_inc >= pay_len_q);
		end

		hit_res                = '0;
		hit_res.result_kind    = RK_HIT;
		hit_res.hit_kind       = dec.hit_kind;
		hit_res.readout_id     = dec.readout_id;
		hit_res.fast_timing    = dec.fast_timing;
		hit_res.adc_value      = dec.adc_value;
		hit_res.tac_value      = dec.tac_value;
		hit_res.time_seconds   = seconds_q;
		hit_res.time_subticks  = subticks_q;

		end_res                = '0;
		end_res.result_kind    = (hits_done_d == exp_hits_d) ? RK_OK : RK_MISMATCH;
		end_res.time_seconds   = seconds_d;
		end_res.time_subticks  = subticks_d;
		end_res.hits_decoded   = hits_done_d;
		end_res.guard_veto     = veto_d;
		end_res.last_of_packet = 1'b1;

		if (pkt_end) begin
			phase_d     = PH_PRIMARY;
			byte_idx_d  = '0;
			pay_len_d   = '0;
			has_time_d  = 1'b0;
			hdr_d       = '0;
			seconds_d   = '0;
			subticks_d  = '0;
			exp_hits_d  = '0;
			hit_bytes_d = '0;
			acc_d       = '0;
			bits_d      = '0;
			hits_done_d = '0;
			dec_stop_d  = 1'b0;
			veto_d      = 1'b0;
		end

		push_n = 2'd0;
		res_a  = '0;
		res_b  = '0;
		if (err) begin
			push_n               = 2'd1;
			res_a.result_kind    = err_kind;
			res_a.last_of_packet = 1'b1;
		end else if (hit_emit && pkt_end) begin
			push_n = 2'd2;
			res_a  = hit_res;
			res_b  = end_res;
		end else if (hit_emit) begin
			push_n = 2'd1;
			res_a  = hit_res;
		end else if (pkt_end) begin
			push_n = 2'd1;
			res_a  = end_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PRIMARY;
			byte_idx_q  <= '0;
			pay_len_q   <= '0;
			has_time_q  <= 1'b0;
			hdr_q       <= '0;
			seconds_q   <= '0;
			subticks_q  <= '0;
			exp_hits_q  <= '0;
			hit_bytes_q <= '0;
			acc_q       <= '0;
			bits_q      <= '0;
			hits_done_q <= '0;
			dec_stop_q  <= 1'b0;
			veto_q      <= 1'b0;
			halted_q    <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			byte_idx_q  <= byte_idx_d;
			pay_len_q   <= pay_len_d;
			has_time_q  <= has_time_d;
			hdr_q       <= hdr_d;
			seconds_q   <= seconds_d;
			subticks_q  <= subticks_d;
			exp_hits_q  <= exp_hits_d;
			hit_bytes_q <= hit_bytes_d;
			acc_q       <= acc_d;
			bits_q      <= bits_d;
			hits_done_q <= hits_done_d;
			dec_stop_q  <= dec_stop_d;
			veto_q      <= veto_d;
			halted_q    <= halted_d;
		end
	end

endmodule

// ----- sv/spkt_out_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per
// transaction. Depends on spkt_pkg.
`timescale 1ns / 1ps

module spkt_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  spkt_pkg::result_t push_a,
	input  spkt_pkg::result_t push_b,
	input  logic              out_ready,
	output logic              out_valid,
	output spkt_pkg::result_t head,
	output logic              room
);
	import spkt_pkg::*;

	result_t           mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_next;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem[rd_ptr_q];
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign wr_next   = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem[wr_ptr_q] <= push_a;
		if (push_n == 2'd2) mem[wr_next] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for space_packet_hit_decoder: drives space packets byte by byte
// and checks every result against a predictor of the parser kept inside this file.
// Depends on spkt_pkg and the space_packet_hit_decoder RTL.
`timescale 1ns / 1ps

module tb_top;
	import spkt_pkg::*;

	// Clock, reset and the ports of the block under test.
	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  result_kind;
	logic [1:0]  hit_kind;
	logic [10:0] readout_id;
	logic        fast_timing;
	logic [13:0] adc_value;
	logic [13:0] tac_value;
	logic [31:0] time_seconds;
	logic [31:0] time_subticks;
	logic [5:0]  hits_decoded;
	logic        guard_veto;
	logic        last_of_packet;

	space_packet_hit_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.hit_kind       (hit_kind),
		.readout_id     (readout_id),
		.fast_timing    (fast_timing),
		.adc_value      (adc_value),
		.tac_value      (tac_value),
		.time_seconds   (time_seconds),
		.time_subticks  (time_subticks),
		.hits_decoded   (hits_decoded),
		.guard_veto     (guard_veto),
		.last_of_packet (last_of_packet)
	);

	always #10 clk = ~clk;

	// Results the parser is expected to produce, oldest first.
	result_t pending_results[$];
	int      error_count;

	// Parser state as predicted from the bytes that have been accepted so far.
	logic [2:0]  ph;
	int unsigned byte_idx;
	int unsigned pay_len;
	bit          time_hdr;
	logic [15:0] hdr;
	logic [31:0] sec_r;
	logic [31:0] sub_r;
	int unsigned want_hits;
	int unsigned hit_left;
	logic [63:0] acc;
	int unsigned held;
	int unsigned hits_seen;
	bit          stopped;
	bit          veto;
	bit          dead;

	// Stimulus side: packet under construction and sender pacing.
	bit          rec_bits[$];
	logic [7:0]  pkt_q[$];
	int          burst_left;
	bit          steady_send;
	int          bytes_sent;

	// Receiver pacing.
	int          rx_mode;
	int          rx_cycle;
	int          stall_left;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Everything that belongs to one packet goes back to its start value; the
	// halted flag is kept, since only reset clears it.
	function automatic void clear_packet_state();
		ph        = PH_PRIMARY;
		byte_idx  = 0;
		pay_len   = 0;
		time_hdr  = 1'b0;
		hdr       = '0;
		sec_r     = '0;
		sub_r     = '0;
		want_hits = 0;
		hit_left  = 0;
		acc       = '0;
		held      = 0;
		hits_seen = 0;
		stopped   = 1'b0;
		veto      = 1'b0;
	endfunction

	function automatic result_t mk_result(logic [2:0] kind, logic [1:0] hk, logic [10:0] id,
			logic ft, logic [13:0] adc, logic [13:0] tac, logic [31:0] sec,
			logic [31:0] sub, logic [5:0] hits, logic vt, logic last);
		result_t r;
		r = '{kind, hk, id, ft, adc, tac, sec, sub, hits, vt, last};
		return r;
	endfunction

	// The accumulator holds the newest bits at the bottom; records are read
	// from the top of the held bits, most significant bit first.
	function automatic int unsigned peek_acc(int unsigned k);
		return int'((acc >> (held - k)) & ((64'd1 << k) - 64'd1));
	endfunction

	function automatic int unsigned take_acc(int unsigned k);
		int unsigned v;
		v = peek_acc(k);
		held -= k;
		acc &= (64'd1 << held) - 64'd1;
		return v;
	endfunction

	// Unpacks as many hit records as are complete, at most two per byte.
	// Decoding ends for the packet when the hit count is reached, when fewer
	// than four bits of hit data are left, on an unknown type nibble, or when
	// what is left of the hit data cannot hold the record.
	function automatic void unpack_records();
		int          n;
		int unsigned avail;
		int unsigned need;
		logic [3:0]  ty;
		logic [10:0] id;
		logic        ft;
		logic [13:0] adc;
		logic [13:0] tac;
		n = 0;
		while (!stopped && n < 2) begin
			id  = '0;
			ft  = 1'b0;
			adc = '0;
			tac = '0;
			if (hits_seen >= want_hits) begin
				stopped = 1'b1;
				break;
			end
			avail = held + 8 * hit_left;
			if (avail < 4) begin
				stopped = 1'b1;
				break;
			end
			if (held < 4)
				break;
			ty = 4'(peek_acc(4));
			if (ty == REC_NORMAL || ty == REC_PULSER)
				need = 44;
			else if (ty == REC_NEIGHBOR)
				need = 36;
			else if (ty == REC_GUARD)
				need = 24;
			else begin
				stopped = 1'b1;
				break;
			end
			if (avail < need) begin
				stopped = 1'b1;
				break;
			end
			if (held < need)
				break;
			void'(take_acc(4));
			if (ty == REC_NEIGHBOR) begin
				id  = 11'(take_acc(11));
				ft  = 1'(take_acc(1));
				adc = 14'(take_acc(10));
				tac = 14'(take_acc(10));
			end else if (ty == REC_GUARD) begin
				// Guard ring records carry a short id, no timing and a spare bit.
				id  = 11'(take_acc(5));
				adc = 14'(take_acc(14));
				void'(take_acc(1));
				veto = 1'b1;
			end else begin
				id  = 11'(take_acc(11));
				ft  = 1'(take_acc(1));
				adc = 14'(take_acc(14));
				tac = 14'(take_acc(14));
			end
			pending_results.push_back(mk_result(RK_HIT, ty[1:0], id, ft, adc, tac,
				sec_r, sub_r, 6'd0, 1'b0, 1'b0));
			n++;
			hits_seen = (hits_seen + 1) & 63;
		end
	endfunction

	// Advances the predicted parser by one accepted byte and queues whatever
	// results that byte causes.
	function automatic void parse_stream_byte(logic [7:0] b);
		int unsigned base;
		int unsigned o;
		logic [10:0] apid;
		if (dead)
			return;

		if (ph == PH_PRIMARY) begin
			if (byte_idx == 0)
				hdr = {b, 8'h00};
			else if (byte_idx == 1)
				hdr[7:0] = b;
			else if (byte_idx == 4)
				pay_len = int'(b) << 8;
			else if (byte_idx == 5) begin
				// Sixth header byte: length is complete and the header is judged.
				apid     = hdr[10:0];
				pay_len  = (pay_len | int'(b)) + 1;
				time_hdr = hdr[11];
				if (apid != APID_A && apid != APID_B && apid != APID_C) begin
					pending_results.push_back(mk_result(RK_BAD_APID, '0, '0, '0, '0, '0,
						'0, '0, '0, '0, 1'b1));
					dead = 1'b1;
					return;
				end
				if (pay_len < (time_hdr ? 15 : 7)) begin
					pending_results.push_back(mk_result(RK_SHORT, '0, '0, '0, '0, '0,
						'0, '0, '0, '0, 1'b1));
					dead = 1'b1;
					return;
				end
				ph       = time_hdr ? PH_TIME : PH_SCIENCE;
				byte_idx = 0;
				return;
			end
			byte_idx++;
			return;
		end

		base = time_hdr ? 8 : 0;
		if (ph == PH_TIME) begin
			if (byte_idx < 4)
				sec_r = {sec_r[23:0], b};
			else
				sub_r = {sub_r[23:0], b};
			if (byte_idx == 7)
				ph = PH_SCIENCE;
		end else if (ph == PH_SCIENCE) begin
			o = byte_idx - base;
			if (o == 4) begin
				want_hits = int'(b[7:2]);
				hit_left  = int'(b[1:0]) << 8;
			end else if (o == 5) begin
				hit_left |= int'(b);
				if (pay_len < base + 7 + hit_left) begin
					pending_results.push_back(mk_result(RK_OVERLONG, '0, '0, '0, '0, '0,
						'0, '0, '0, '0, 1'b1));
					dead = 1'b1;
					return;
				end
			end else if (o == 6) begin
				ph = (hit_left != 0) ? PH_HITS : PH_SKIP;
			end
		end else if (ph == PH_HITS) begin
			hit_left = (hit_left - 1) & 10'h3FF;
			if (!stopped) begin
				acc  = (acc << 8) | 64'(b);
				held += 8;
			end
			unpack_records();
			if (hit_left == 0) begin
				ph      = PH_SKIP;
				stopped = 1'b1;
			end
		end

		byte_idx++;
		if (byte_idx >= pay_len) begin
			pending_results.push_back(mk_result(
				(hits_seen == want_hits) ? RK_OK : RK_MISMATCH, '0, '0, '0, '0, '0,
				sec_r, sub_r, 6'(hits_seen), veto, 1'b1));
			clear_packet_state();
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch({"field ", name}, got, want);
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got = '{result_kind, hit_kind, readout_id, fast_timing, adc_value, tac_value,
			time_seconds, time_subticks, hits_decoded, guard_veto, last_of_packet};
		if (pending_results.size() == 0) begin
			report_mismatch("result with none expected, kind", 32'(got.result_kind), '0);
			return;
		end
		want = pending_results.pop_front();
		cmp_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		cmp_field("hit_kind", 32'(got.hit_kind), 32'(want.hit_kind));
		cmp_field("readout_id", 32'(got.readout_id), 32'(want.readout_id));
		cmp_field("fast_timing", 32'(got.fast_timing), 32'(want.fast_timing));
		cmp_field("adc_value", 32'(got.adc_value), 32'(want.adc_value));
		cmp_field("tac_value", 32'(got.tac_value), 32'(want.tac_value));
		cmp_field("time_seconds", got.time_seconds, want.time_seconds);
		cmp_field("time_subticks", got.time_subticks, want.time_subticks);
		cmp_field("hits_decoded", 32'(got.hits_decoded), 32'(want.hits_decoded));
		cmp_field("guard_veto", 32'(got.guard_veto), 32'(want.guard_veto));
		cmp_field("last_of_packet", 32'(got.last_of_packet), 32'(want.last_of_packet));
	endtask

	// Both handshakes are observed at the rising edge. The output transaction
	// is checked before the input transaction of the same edge is predicted,
	// so the outcome never depends on the order in which processes wake up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				parse_stream_byte(data_byte);
		end
	end

	// The receiver changes at random between three habits: always ready, ready
	// at random three times in four, and mostly ready with occasional long stalls.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if ($urandom_range(0, 9) == 0) begin
						stall_left = $urandom_range(1, 12);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_mode = $urandom_range(0, 2);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Sends one byte as one transaction. Called at a falling edge and returns
	// at a falling edge. Bytes go out in bursts of random length; between
	// bursts valid drops for a random gap unless steady sending is selected.
	task automatic send_byte(logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!steady_send) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected result has come out.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_field(int w);
		logic [63:0] mask;
		mask = (64'd1 << w) - 64'd1;
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return mask[31:0];
			default: return 32'($urandom) & mask[31:0];
		endcase
	endfunction

	function automatic void push_bits(logic [31:0] v, int w);
		for (int i = w - 1; i >= 0; i--)
			rec_bits.push_back(v[i]);
	endfunction

	// Appends one hit record to the hit data. An unknown type puts down only
	// its nibble; whatever follows is up to the caller.
	function automatic void add_record(logic [3:0] ty, logic [10:0] id, logic ft,
			logic [13:0] adc, logic [13:0] tac);
		push_bits(32'(ty), 4);
		if (ty == REC_NORMAL || ty == REC_PULSER) begin
			push_bits(32'(id), 11);
			push_bits(32'(ft), 1);
			push_bits(32'(adc), 14);
			push_bits(32'(tac), 14);
		end else if (ty == REC_NEIGHBOR) begin
			push_bits(32'(id), 11);
			push_bits(32'(ft), 1);
			push_bits(32'(adc), 10);
			push_bits(32'(tac), 10);
		end else if (ty == REC_GUARD) begin
			push_bits(32'(id), 5);
			push_bits(32'(adc), 14);
			push_bits($urandom_range(0, 1), 1);
		end
	endfunction

	function automatic void add_random_record();
		add_record(4'($urandom_range(0, 3)), 11'(pick_field(11)), 1'(pick_field(1)),
			14'(pick_field(14)), 14'(pick_field(14)));
	endfunction

	// Bytes of hit data that the records put down so far fill, once padded.
	function automatic int natural_hit_len();
		return (rec_bits.size() + 7) / 8;
	endfunction

	// Lays out a whole packet in pkt_q: primary header, optional time header,
	// science header, hit_len bytes of hit data (negative means exactly what
	// the records need; a shorter length cuts them, a longer one adds random
	// bytes) and trailing random bytes. The length field matches the layout.
	function automatic void build_packet(logic [10:0] apid, bit tflag, logic [31:0] sec,
			logic [31:0] sub, logic [5:0] count, int hit_len, int trailing);
		int          natural;
		int          pay;
		logic [15:0] hw;
		logic [15:0] lenf;
		logic [9:0]  hl10;
		logic [7:0]  by;
		while (rec_bits.size() % 8 != 0)
			rec_bits.push_back(1'($urandom_range(0, 1)));
		natural = rec_bits.size() / 8;
		if (hit_len < 0)
			hit_len = natural;
		hl10 = 10'(hit_len);
		pay  = (tflag ? 8 : 0) + 7 + hit_len + trailing;
		hw   = {4'($urandom_range(0, 15)), tflag, apid};
		lenf = 16'(pay - 1);
		pkt_q.delete();
		pkt_q.push_back(hw[15:8]);
		pkt_q.push_back(hw[7:0]);
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(8'($urandom));
		pkt_q.push_back(lenf[15:8]);
		pkt_q.push_back(lenf[7:0]);
		if (tflag) begin
			for (int i = 3; i >= 0; i--)
				pkt_q.push_back(sec[8*i +: 8]);
			for (int i = 3; i >= 0; i--)
				pkt_q.push_back(sub[8*i +: 8]);
		end
		// Truncated time, hit count with the length, and the event type byte.
		for (int i = 0; i < 4; i++)
			pkt_q.push_back(8'($urandom));
		pkt_q.push_back({count, hl10[9:8]});
		pkt_q.push_back(hl10[7:0]);
		pkt_q.push_back(8'($urandom));
		for (int i = 0; i < hit_len; i++) begin
			if (i < natural) begin
				by = '0;
				for (int j = 0; j < 8; j++)
					by = {by[6:0], rec_bits[8*i + j]};
				pkt_q.push_back(by);
			end else begin
				pkt_q.push_back(8'($urandom));
			end
		end
		for (int i = 0; i < trailing; i++)
			pkt_q.push_back(8'($urandom));
		rec_bits.delete();
	endfunction

	task automatic send_packet();
		foreach (pkt_q[i])
			send_byte(pkt_q[i]);
	endtask

	function automatic logic [10:0] pick_apid();
		case ($urandom_range(0, 2))
			0: return APID_A;
			1: return APID_B;
			default: return APID_C;
		endcase
	endfunction

	// A packet with an accepted APID and a length that fits, so the parser
	// never halts. Most are well formed; the rest carry a wrong hit count,
	// junk after the records, cut or padded hit data, or trailing bytes.
	task automatic send_random_packet();
		int          nrec;
		int          cnt;
		int          hl;
		int          trail;
		int          r;
		logic [10:0] apid;
		bit          tf;
		logic [31:0] sec;
		logic [31:0] sub;
		apid = pick_apid();
		tf   = 1'($urandom_range(0, 1));
		sec  = pick_field(32);
		sub  = pick_field(32);
		r    = $urandom_range(0, 99);
		if (r < 70)
			nrec = $urandom_range(0, 4);
		else if (r < 98)
			nrec = $urandom_range(5, 12);
		else
			nrec = $urandom_range(40, 63);
		for (int i = 0; i < nrec; i++)
			add_random_record();
		cnt   = nrec;
		hl    = -1;
		trail = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
		case ($urandom_range(0, 9))
			0: cnt = $urandom_range(0, 63);
			1: begin
				// Junk with an unknown type nibble after the last record.
				push_bits($urandom_range(4, 15), 4);
				push_bits($urandom, $urandom_range(0, 20));
				cnt = (nrec < 63) ? nrec + 1 : nrec;
			end
			2: if (natural_hit_len() > 0) hl = $urandom_range(0, natural_hit_len() - 1);
			3: hl = natural_hit_len() + $urandom_range(1, 6);
			4: cnt = (nrec < 63) ? nrec + 1 : nrec;
			default: ;
		endcase
		build_packet(apid, tf, sec, sub, 6'(cnt), hl, trail);
		send_packet();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Header variants: the smallest legal packet, the time header with extreme
	// values, every record type at all ones, the normal and pulser types at zero, a
	// count that claims more hits than present, and bytes after the hit data.
	task automatic test_packet_basics();
		build_packet(APID_A, 1'b0, '0, '0, 6'd0, 0, 0);
		send_packet();

		add_record(REC_NORMAL, 11'h7FF, 1'b1, 14'h3FFF, 14'h3FFF);
		add_record(REC_NEIGHBOR, 11'h7FF, 1'b1, 14'h3FF, 14'h3FF);
		add_record(REC_GUARD, 11'h1F, 1'b0, 14'h3FFF, 14'h0);
		add_record(REC_PULSER, 11'h7FF, 1'b1, 14'h3FFF, 14'h3FFF);
		build_packet(APID_B, 1'b1, 32'hFFFF_FFFF, 32'h0, 6'd4, -1, 0);
		send_packet();

		add_record(REC_PULSER, '0, 1'b0, '0, '0);
		add_record(REC_NORMAL, '0, 1'b0, '0, '0);
		build_packet(APID_C, 1'b1, 32'h0, 32'hFFFF_FFFF, 6'd3, -1, 2);
		send_packet();
	endtask

	// Ways decoding can end early, plus the largest hit count.
	task automatic test_decode_stops();
		// Unknown type nibble after a good record.
		add_record(REC_NORMAL, 11'h123, 1'b1, 14'h0ABC, 14'h1234);
		add_record(4'hC, '0, 1'b0, '0, '0);
		push_bits($urandom, 12);
		build_packet(APID_A, 1'b0, '0, '0, 6'd3, -1, 0);
		send_packet();

		// Hit data too short to hold the record it starts.
		add_record(REC_NORMAL, 11'h456, 1'b0, 14'h2222, 14'h1111);
		build_packet(APID_B, 1'b0, '0, '0, 6'd1, 3, 0);
		send_packet();

		// Count reached before the hit data runs out.
		add_record(REC_NEIGHBOR, 11'h001, 1'b1, 14'h155, 14'h2AA);
		add_record(REC_GUARD, 11'h0A, 1'b0, 14'h2AAA, 14'h0);
		build_packet(APID_C, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 6'd1, -1, 1);
		send_packet();

		// Hit count claims hits but there is no hit data at all.
		build_packet(APID_A, 1'b1, 32'h0000_0001, 32'h8000_0000, 6'd5, 0, 0);
		send_packet();

		// The largest hit count, all guard ring hits.
		for (int i = 0; i < 63; i++)
			add_record(REC_GUARD, 11'(pick_field(5)), 1'b0, 14'(pick_field(14)), '0);
		build_packet(APID_B, 1'b0, '0, '0, 6'd63, -1, 0);
		send_packet();
	endtask

	// Random packets; halfway through the sender holds off until the result
	// queue has emptied.
	task automatic test_random_packets();
		int  start;
		bit  paused;
		start  = bytes_sent;
		paused = 1'b0;
		while (bytes_sent < start + 400) begin
			steady_send = ($urandom_range(0, 4) == 0);
			send_random_packet();
			if (!paused && bytes_sent >= start + 200) begin
				wait_results_drained();
				paused = 1'b1;
			end
		end
		steady_send = 1'b0;
	endtask

	// One of the three halting errors, picked at random since only reset
	// clears the halt; afterwards a few bytes that must be ignored.
	task automatic test_halt_on_error();
		int          pick;
		int          base;
		int          plen;
		int          hl;
		bit          tf;
		logic [10:0] apid;
		pick = $urandom_range(0, 2);
		tf   = 1'($urandom_range(0, 1));
		base = tf ? 8 : 0;
		case (pick)
			0: begin
				// APID outside the accepted set.
				do apid = 11'($urandom);
				while (apid == APID_A || apid == APID_B || apid == APID_C);
				add_random_record();
				build_packet(apid, tf, pick_field(32), pick_field(32), 6'd1, -1, 0);
			end
			1: begin
				// Payload too small for the time header and science header.
				build_packet(pick_apid(), tf, pick_field(32), pick_field(32), 6'd0, 0, 0);
				plen     = $urandom_range(1, base + 6);
				pkt_q[4] = '0;
				pkt_q[5] = 8'(plen - 1);
			end
			default: begin
				// Hit data length beyond what the payload length allows.
				add_random_record();
				add_random_record();
				hl = natural_hit_len();
				build_packet(pick_apid(), tf, pick_field(32), pick_field(32), 6'd2, -1, 0);
				plen     = $urandom_range(base + 7, base + 6 + hl);
				pkt_q[4] = 8'((plen - 1) >> 8);
				pkt_q[5] = 8'(plen - 1);
			end
		endcase
		send_packet();
		repeat (8) send_byte(8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = '0;
		out_ready   = 1'b0;
		error_count = 0;
		burst_left  = 0;
		steady_send = 1'b0;
		bytes_sent  = 0;
		rx_mode     = 0;
		rx_cycle    = 0;
		stall_left  = 0;
		dead        = 1'b0;
		clear_packet_state();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_packet_basics();
		test_decode_stops();
		test_random_packets();
		test_halt_on_error();

		// A few spare cycles let any stray result show up before the verdict.
		wait_results_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("[space_packet_hit_decoder] OK");
		end else begin
			if (pending_results.size() != 0)
				$display("%0d expected results never arrived", pending_results.size());
			$display("[space_packet_hit_decoder] ERROR");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("[space_packet_hit_decoder] ERROR");
		$finish;
	end

endmodule
